// ----- src/ple_pkg.sv -----
// positional list engine: shared types, action and status codes
// used by ple_cell and positional_list_engine_top; no dependencies
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY_DEF  = 256;
    localparam int WORD_BITS_DEF = 32;
    localparam int ACT_W         = 4;
    localparam int STATUS_W      = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INS_POS   = 4'd0,
        ACT_INS_FRONT = 4'd1,
        ACT_INS_BACK  = 4'd2,
        ACT_REM_POS   = 4'd3,
        ACT_REM_FRONT = 4'd4,
        ACT_REM_BACK  = 4'd5,
        ACT_READ      = 4'd6,
        ACT_RESTART   = 4'd7,
        ACT_NEXT      = 4'd8
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_REM  = 2'd2
    } t_shift_op;

    typedef struct packed {
        t_shift_op op;
        logic      tap_load;
        logic      tap_shift;
    } t_cell_ctl;

endpackage

// ----- src/ple_cell.sv -----
// one list cell: holds one entry and one tap register of the read chain
// depends on ple_pkg
`timescale 1ns / 1ps

module ple_cell #(
    parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF,
    parameter int POS_W     = 9,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  ple_pkg::t_cell_ctl   i_ctl,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [WORD_BITS-1:0] i_left,
    input  logic [WORD_BITS-1:0] i_right,
    input  logic [WORD_BITS-1:0] i_tap_right,
    output logic [WORD_BITS-1:0] o_data,
    output logic [WORD_BITS-1:0] o_tap
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] r_tap;
    logic [WORD_BITS-1:0] n_data;
    logic [WORD_BITS-1:0] n_tap;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            SH_INS: begin
                if (i_pos == MY_IDX) begin
                    n_data = i_word;
                end else if (i_pos < MY_IDX) begin
                    n_data = i_left;
                end
            end
            SH_REM: begin
                if (i_pos <= MY_IDX) begin
                    n_data = i_right;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_comb begin
        n_tap = r_tap;
        if (i_ctl.tap_load) begin
            n_tap = r_data;
        end else if (i_ctl.tap_shift) begin
            n_tap = i_tap_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

// ----- src/positional_list_engine_top.sv -----
// positional list engine top: control, counters and the row of ple_cell
// depends on ple_pkg and ple_cell
`timescale 1ns / 1ps
//
// channel | dir | tdata fields, lowest bit first
// s       | in  | action[3:0], position[POS_W], word_in[WORD_BITS], zero pad
// m       | out | status[1:0], word_out[WORD_BITS], element_count[POS_W], zero pad
//
// a remove, read or traversal step at position p has its result registered once the word has
// walked down the tap chain one cell per cycle from cell p to cell 0; an insert or a failed
// action skips the walk; the engine returns to idle as the result is registered
// all cells shift in parallel in the accept cycle
// synchronous active-low reset clears count, cursor and control; entries are not cleared
// a stalled result is held in the output register; the next transaction is accepted and
// its result waits at the end of its walk until the output register frees

module positional_list_engine_top #(
    parameter int CAPACITY  = ple_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF,
    localparam int POS_W    = $clog2(CAPACITY + 1),
    localparam int IN_W     = ((ple_pkg::ACT_W + POS_W + WORD_BITS + 7) / 8) * 8,
    localparam int OUT_W    = ((ple_pkg::STATUS_W + WORD_BITS + POS_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // action, position, word_in
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status, word_out, element_count
);
    import ple_pkg::*;

    localparam logic [POS_W-1:0] CAP_V = POS_W'(CAPACITY);
    localparam logic [POS_W-1:0] ONE_V = POS_W'(1);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state r_state;

    logic [POS_W-1:0]     r_count;
    logic [POS_W-1:0]     r_cursor;
    logic [POS_W-1:0]     r_steps;
    t_status              r_pend_status;
    logic [POS_W-1:0]     r_pend_count;
    logic                 r_pend_word;
    logic                 r_m_tvalid;
    t_status              r_status;
    logic [WORD_BITS-1:0] r_word;
    logic [POS_W-1:0]     r_count_out;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_emit;
    t_action              w_act;
    logic [POS_W-1:0]     w_pos;
    logic [WORD_BITS-1:0] w_word_in;

    t_status              c_status;
    t_shift_op            c_op;
    logic [POS_W-1:0]     c_pos;
    logic [POS_W-1:0]     c_idx;
    logic [POS_W-1:0]     n_count;
    logic [POS_W-1:0]     n_cursor;
    logic                 c_walk;
    t_cell_ctl            w_ctl;

    logic [WORD_BITS-1:0] w_data [CAPACITY];
    logic [WORD_BITS-1:0] w_tap  [CAPACITY];

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_tvalid || i_m_tready;
    assign w_emit     = (r_state == S_WALK) && (r_steps == '0) && w_out_free;

    assign w_act     = t_action'(i_s_tdata[ACT_W-1:0]);
    assign w_pos     = i_s_tdata[ACT_W +: POS_W];
    assign w_word_in = i_s_tdata[ACT_W + POS_W +: WORD_BITS];

    always_comb begin
        c_status = ST_NONE;
        c_op     = SH_HOLD;
        c_pos    = w_pos;
        c_idx    = '0;
        c_walk   = 1'b0;
        n_count  = r_count;
        n_cursor = r_cursor;
        case (w_act)
            ACT_INS_POS, ACT_INS_FRONT, ACT_INS_BACK: begin
                if (w_act == ACT_INS_FRONT) begin
                    c_pos = '0;
                end else if (w_act == ACT_INS_BACK) begin
                    c_pos = r_count;
                end
                if (c_pos > r_count) begin
                    c_status = ST_NONE;
                end else if (r_count >= CAP_V) begin
                    c_status = ST_FULL;
                end else begin
                    c_status = ST_OK;
                    c_op     = SH_INS;
                    n_count  = r_count + ONE_V;
                end
            end
            ACT_REM_POS, ACT_REM_FRONT, ACT_REM_BACK: begin
                if (w_act == ACT_REM_FRONT) begin
                    c_pos = '0;
                end else if (w_act == ACT_REM_BACK) begin
                    c_pos = r_count - ONE_V;
                end
                if (r_count != '0 && c_pos < r_count) begin
                    c_status = ST_OK;
                    c_op     = SH_REM;
                    c_walk   = 1'b1;
                    c_idx    = c_pos;
                    n_count  = r_count - ONE_V;
                end
            end
            ACT_READ: begin
                if (w_pos < r_count) begin
                    c_status = ST_OK;
                    c_walk   = 1'b1;
                    c_idx    = w_pos;
                end
            end
            ACT_RESTART: begin
                if (r_count != '0) begin
                    c_status = ST_OK;
                    c_walk   = 1'b1;
                    c_idx    = '0;
                    n_cursor = ONE_V;
                end
            end
            ACT_NEXT: begin
                if (r_cursor < r_count) begin
                    c_status = ST_OK;
                    c_walk   = 1'b1;
                    c_idx    = r_cursor;
                    n_cursor = r_cursor + ONE_V;
                end
            end
            default: c_status = ST_NONE;
        endcase
    end

    always_comb begin
        w_ctl.op        = w_accept ? c_op : SH_HOLD;
        w_ctl.tap_load  = w_accept;
        w_ctl.tap_shift = (r_state == S_WALK) && (r_steps != '0);
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        logic [WORD_BITS-1:0] w_tap_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right     = '0;
            assign w_tap_right = '0;
        end else begin : g_inner
            assign w_right     = w_data[g+1];
            assign w_tap_right = w_tap[g+1];
        end
        ple_cell #(
            .WORD_BITS (WORD_BITS),
            .POS_W     (POS_W),
            .IDX       (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (c_pos),
            .i_word      (w_word_in),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_tap_right (w_tap_right),
            .o_data      (w_data[g]),
            .o_tap       (w_tap[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_cursor     <= '0;
            r_steps      <= '0;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count       <= n_count;
                        r_cursor      <= n_cursor;
                        r_steps       <= c_walk ? c_idx : '0;
                        r_pend_status <= c_status;
                        r_pend_count  <= n_count;
                        r_pend_word   <= c_walk;
                        r_state       <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_steps != '0) begin
                        r_steps <= r_steps - ONE_V;
                    end else if (w_out_free) begin
                        r_status    <= r_pend_status;
                        r_word      <= r_pend_word ? w_tap[0] : '0;
                        r_count_out <= r_pend_count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = OUT_W'({r_count_out, r_word, r_status});

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_V)
    else $error("element count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CAP_V)
    else $error("traversal cursor above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid && (r_status == ST_FULL) |-> (r_count_out == CAP_V))
    else $error("full status without a full list");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid && (r_status != ST_OK) |-> (r_word == '0))
    else $error("nonzero word on a failed transaction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_count == $past(r_count) || r_count == $past(r_count) + ONE_V
                      || r_count + ONE_V == $past(r_count)))
    else $error("element count moved by more than one");

endmodule
